[design/rbsi_pkg.sv]
// Shared types and constants for the ray/box slab intersection core.
// No dependencies; used by rbsi_recip and ray_box_slab_intersect_core.
package rbsi_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WIDE_W        = 80;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Z = 3'd5;

	localparam logic [2:0] FACE_NEG_X = 3'd0;
	localparam logic [2:0] FACE_POS_X = 3'd1;
	localparam logic [2:0] FACE_NEG_Y = 3'd2;
	localparam logic [2:0] FACE_POS_Y = 3'd3;
	localparam logic [2:0] FACE_NEG_Z = 3'd4;
	localparam logic [2:0] FACE_POS_Z = 3'd5;

	typedef struct packed {
		logic [2:0][DATA_W-1:0] dir;
		logic [2:0][DATA_W-1:0] org;
	} ray_t;

	function automatic logic [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(signed'(32'sh7FFF_FFFF));
		lo = -hi - WIDE_W'(1);
		if (v > hi) return 32'h7FFF_FFFF;
		if (v < lo) return 32'h8000_0000;
		return v[DATA_W-1:0];
	endfunction

endpackage

[design/ray_box_slab_intersect_core.sv]
// Top level of the ray/box slab intersection core.
// Depends on rbsi_pkg and rbsi_recip.
// One ray is accepted per clock while the output is not stalled, and every ray yields one result transaction.
// Each ray passes through the bit-serial reciprocal pipeline (one quotient bit per
// stage) followed by five stages for slab distances, min/max selection, point
// products and the output register.
// All stages advance together; a stall on the output holds the whole pipeline.
// Write the box registers only while no ray is in flight.
module ray_box_slab_intersect_core #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [191:0]                      s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// hit, t_enter, t_exit, entry_face, entry_x/y/z, exit_x/y/z, zero pad
	output logic [263:0]                      m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rbsi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbsi_pkg::DATA_W-1:0]       cfg_data
);

	localparam int LAT = 2 * FRAC_BITS + 2;
	localparam logic signed [31:0] HIT_EPS = 32'(((1 << FRAC_BITS) + 9999) / 10000);
	localparam logic [2:0] FACE_NEG [3] = '{rbsi_pkg::FACE_NEG_X, rbsi_pkg::FACE_NEG_Y,
		rbsi_pkg::FACE_NEG_Z};
	localparam logic [2:0] FACE_POS [3] = '{rbsi_pkg::FACE_POS_X, rbsi_pkg::FACE_POS_Y,
		rbsi_pkg::FACE_POS_Z};

	logic signed [31:0] box_lo_q [3];
	logic signed [31:0] box_hi_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				box_lo_q[a] <= '0;
				box_hi_q[a] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rbsi_pkg::CFG_BOX_LOW_X:  box_lo_q[0] <= cfg_data;
				rbsi_pkg::CFG_BOX_LOW_Y:  box_lo_q[1] <= cfg_data;
				rbsi_pkg::CFG_BOX_LOW_Z:  box_lo_q[2] <= cfg_data;
				rbsi_pkg::CFG_BOX_HIGH_X: box_hi_q[0] <= cfg_data;
				rbsi_pkg::CFG_BOX_HIGH_Y: box_hi_q[1] <= cfg_data;
				rbsi_pkg::CFG_BOX_HIGH_Z: box_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic vld_s5;
	assign en            = !vld_s5 || m_axis_tready;
	assign s_axis_tready = en;

	rbsi_pkg::ray_t ray_in;
	assign ray_in = s_axis_tdata;

	// reciprocal lanes and matching delay line
	logic signed [31:0] recip [3];
	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_recip
			rbsi_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
				.clk   (clk),
				.en    (en),
				.dir   (ray_in.dir[g]),
				.recip (recip[g])
			);
		end
	endgenerate

	rbsi_pkg::ray_t ray_dl_q [LAT];
	logic [LAT-1:0] vld_dl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_dl_q <= '0;
		else if (en) vld_dl_q <= {vld_dl_q[LAT-2:0], s_axis_tvalid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_dl_q[0] <= ray_in;
			for (int i = 1; i < LAT; i++) ray_dl_q[i] <= ray_dl_q[i-1];
		end
	end

	// stage 1: plane distance products
	logic signed [64:0] pl_s1 [3];
	logic signed [64:0] ph_s1 [3];
	logic               rneg_s1 [3];
	rbsi_pkg::ray_t     ray_s1;
	logic               vld_s1;
	logic signed [32:0] dlo [3];
	logic signed [32:0] dhi [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dlo[a] = box_lo_q[a] - signed'(ray_dl_q[LAT-1].org[a]);
			dhi[a] = box_hi_q[a] - signed'(ray_dl_q[LAT-1].org[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				pl_s1[a]   <= dlo[a] * recip[a];
				ph_s1[a]   <= dhi[a] * recip[a];
				rneg_s1[a] <= recip[a][31];
			end
			ray_s1 <= ray_dl_q[LAT-1];
		end
	end

	// stage 2: shift, saturate, order
	logic signed [31:0] tmin_s2 [3];
	logic signed [31:0] tmax_s2 [3];
	logic [2:0]         face_s2 [3];
	rbsi_pkg::ray_t     ray_s2;
	logic               vld_s2;
	logic signed [rbsi_pkg::WIDE_W-1:0] wl [3];
	logic signed [rbsi_pkg::WIDE_W-1:0] wh [3];
	logic signed [31:0] tl [3];
	logic signed [31:0] th [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			wl[a] = pl_s1[a] >>> FRAC_BITS;
			wh[a] = ph_s1[a] >>> FRAC_BITS;
			tl[a] = rbsi_pkg::sat32(wl[a]);
			th[a] = rbsi_pkg::sat32(wh[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				tmin_s2[a] <= rneg_s1[a] ? th[a] : tl[a];
				tmax_s2[a] <= rneg_s1[a] ? tl[a] : th[a];
				face_s2[a] <= rneg_s1[a] ? FACE_POS[a] : FACE_NEG[a];
			end
			ray_s2 <= ray_s1;
		end
	end

	// stage 3: entry/exit selection and hit
	logic signed [31:0] t0_s3;
	logic signed [31:0] t1_s3;
	logic [2:0]         face_s3;
	logic               hit_s3;
	rbsi_pkg::ray_t     ray_s3;
	logic               vld_s3;
	logic signed [31:0] t0;
	logic signed [31:0] t1;
	logic [2:0]         face;

	always_comb begin
		if (tmin_s2[0] > tmin_s2[1]) begin
			t0   = tmin_s2[0];
			face = face_s2[0];
		end else begin
			t0   = tmin_s2[1];
			face = face_s2[1];
		end
		if (tmin_s2[2] > t0) begin
			t0   = tmin_s2[2];
			face = face_s2[2];
		end
		t1 = (tmax_s2[0] < tmax_s2[1]) ? tmax_s2[0] : tmax_s2[1];
		if (tmax_s2[2] < t1) t1 = tmax_s2[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s3   <= t0;
			t1_s3   <= t1;
			face_s3 <= face;
			hit_s3  <= (t0 < t1) && (t1 > HIT_EPS);
			ray_s3  <= ray_s2;
		end
	end

	// stage 4: point products
	logic signed [63:0] pe_s4 [3];
	logic signed [63:0] px_s4 [3];
	logic signed [31:0] t0_s4;
	logic signed [31:0] t1_s4;
	logic [2:0]         face_s4;
	logic               hit_s4;
	rbsi_pkg::ray_t     ray_s4;
	logic               vld_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				pe_s4[a] <= signed'(ray_s3.dir[a]) * t0_s3;
				px_s4[a] <= signed'(ray_s3.dir[a]) * t1_s3;
			end
			t0_s4   <= t0_s3;
			t1_s4   <= t1_s3;
			face_s4 <= face_s3;
			hit_s4  <= hit_s3;
			ray_s4  <= ray_s3;
		end
	end

	// stage 5: output register
	logic signed [rbsi_pkg::WIDE_W-1:0] we [3];
	logic signed [rbsi_pkg::WIDE_W-1:0] wx [3];
	logic [31:0] ent_s5 [3];
	logic [31:0] ext_s5 [3];
	logic [31:0] t0_s5;
	logic [31:0] t1_s5;
	logic [2:0]  face_s5;
	logic        hit_s5;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			we[a] = pe_s4[a] >>> FRAC_BITS;
			wx[a] = px_s4[a] >>> FRAC_BITS;
			we[a] = we[a] + signed'(ray_s4.org[a]);
			wx[a] = wx[a] + signed'(ray_s4.org[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				ent_s5[a] <= rbsi_pkg::sat32(we[a]);
				ext_s5[a] <= rbsi_pkg::sat32(wx[a]);
			end
			t0_s5   <= t0_s4;
			t1_s5   <= t1_s4;
			face_s5 <= face_s4;
			hit_s5  <= hit_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_dl_q[LAT-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = {4'd0, ext_s5[2], ext_s5[1], ext_s5[0],
		ent_s5[2], ent_s5[1], ent_s5[0], face_s5, t1_s5, t0_s5, hit_s5};

endmodule

[design/rbsi_recip.sv]
// Pipelined reciprocal 2^(2*FRAC_BITS)/dir, one quotient bit per stage, saturated.
// Depends on rbsi_pkg.
module rbsi_recip #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [rbsi_pkg::DATA_W-1:0] dir,
	output logic signed [rbsi_pkg::DATA_W-1:0] recip
);

	localparam int QW = 2 * FRAC_BITS + 1;

	logic [31:0]   dv_s   [QW];
	logic [31:0]   rem_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic          neg_s  [QW];
	logic          zero_s [QW];

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_stage
			logic [31:0]   dv_in;
			logic [31:0]   rem_in;
			logic [QW-1:0] quo_in;
			logic          neg_in;
			logic          zero_in;
			logic [32:0]   shifted;
			logic          ge;
			if (k == 0) begin : g_first
				always_comb begin
					dv_in   = dir[31] ? (~dir + 32'd1) : dir;
					rem_in  = '0;
					quo_in  = '0;
					neg_in  = dir[31];
					zero_in = (dir == '0);
				end
			end else begin : g_rest
				always_comb begin
					dv_in   = dv_s[k-1];
					rem_in  = rem_s[k-1];
					quo_in  = quo_s[k-1];
					neg_in  = neg_s[k-1];
					zero_in = zero_s[k-1];
				end
			end
			always_comb begin
				shifted = {rem_in, (k == 0)};
				ge      = shifted >= {1'b0, dv_in};
			end
			always_ff @(posedge clk) begin
				if (en) begin
					dv_s[k]   <= dv_in;
					rem_s[k]  <= ge ? 32'(shifted - {1'b0, dv_in}) : shifted[31:0];
					quo_s[k]  <= {quo_in[QW-2:0], ge};
					neg_s[k]  <= neg_in;
					zero_s[k] <= zero_in;
				end
			end
		end
	endgenerate

	logic [63:0] quo_w;
	assign quo_w = 64'(quo_s[QW-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[QW-1] || (!neg_s[QW-1] && quo_w > 64'h7FFF_FFFF))
				recip <= 32'sh7FFF_FFFF;
			else if (neg_s[QW-1] && quo_w > 64'h8000_0000)
				recip <= 32'sh8000_0000;
			else if (neg_s[QW-1])
				recip <= 32'(~quo_w + 64'd1);
			else
				recip <= quo_w[31:0];
		end
	end

endmodule
